>>> hdl/rgb_sobel_edge_magnitude_top_defines.svh
// ----------------------------------------------------------------------------
// rgb sobel edge magnitude - assertion macros
// shared checking helpers, clocked on clk and disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef RGB_SOBEL_EDGE_MAGNITUDE_TOP_DEFINES_SVH
`define RGB_SOBEL_EDGE_MAGNITUDE_TOP_DEFINES_SVH

// property must hold at every edge out of reset
`define RSEM_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("rsem check failed");

// condition must never be seen out of reset
`define RSEM_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error("rsem forbidden condition");

`endif

>>> hdl/rsem_pkg.sv
// ----------------------------------------------------------------------------
// rsem_pkg
// types and constants shared by the sobel edge magnitude block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rsem_pkg;

  localparam int PIX_BITS     = 8;
  localparam int FW_BITS      = 11;
  localparam int FH_BITS      = 16;
  localparam int CFG_BITS     = 16;
  localparam int CFG_IDX_BITS = 2;
  localparam int SUM_BITS     = 22;

  localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_HEIGHT = 2'd1;

  // largest sum of squares whose root still rounds below 256
  localparam logic [SUM_BITS-1:0] ROOT_SAT = 22'd65280;
  localparam logic [PIX_BITS-1:0] MAG_MAX  = 8'd255;

  typedef logic [2:0][2:0][PIX_BITS-1:0] win_bytes_t;  // [row][column]

  typedef struct packed {
    logic [2:0] col_ok;
    logic [2:0] row_ok;
  } edge_mask_t;

endpackage

>>> hdl/rsem_lane.sv
// ----------------------------------------------------------------------------
// rsem_lane
// one colour channel: sobel gradients, sum of squares, bit-serial rounded root
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rsem_lane (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  rsem_pkg::win_bytes_t      win,
  input  rsem_pkg::edge_mask_t      mask,
  output logic                      done,
  output logic [rsem_pkg::PIX_BITS-1:0] mag
);
  import rsem_pkg::*;

  typedef enum logic [1:0] {L_IDLE, L_SQ, L_ROOT, L_ROUND} lane_state_t;

  lane_state_t              state_r;
  logic signed [11:0]       gx_r, gy_r;
  logic [SUM_BITS-1:0]      s_r;
  logic [PIX_BITS-1:0]      n_r;
  logic [2:0]               k_r;
  logic                     done_r;
  logic [PIX_BITS-1:0]      mag_r;

  win_bytes_t               v;
  logic signed [11:0]       gx_nxt, gy_nxt;
  logic signed [23:0]       gx_sq, gy_sq;
  logic [PIX_BITS-1:0]      t;
  logic [15:0]              t_sq;
  logic [16:0]              n_lim;

  // zero padding outside the frame
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        v[r][c] = (mask.row_ok[r] && mask.col_ok[c]) ? win[r][c] : '0;
      end
    end
    gx_nxt = (12'(v[0][2]) + 12'({v[1][2], 1'b0}) + 12'(v[2][2]))
           - (12'(v[0][0]) + 12'({v[1][0], 1'b0}) + 12'(v[2][0]));
    gy_nxt = (12'(v[2][0]) + 12'({v[2][1], 1'b0}) + 12'(v[2][2]))
           - (12'(v[0][0]) + 12'({v[0][1], 1'b0}) + 12'(v[0][2]));
  end

  assign gx_sq = gx_r * gx_r;
  assign gy_sq = gy_r * gy_r;
  assign t     = n_r | (PIX_BITS'(1) << k_r);
  assign t_sq  = t * t;
  assign n_lim = 17'(n_r) * 17'(n_r) + 17'(n_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= L_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (state_r)
        L_IDLE: begin
          if (start) begin
            gx_r    <= gx_nxt;
            gy_r    <= gy_nxt;
            state_r <= L_SQ;
          end
        end
        L_SQ: begin
          s_r     <= SUM_BITS'(gx_sq) + SUM_BITS'(gy_sq);
          n_r     <= '0;
          k_r     <= 3'd7;
          state_r <= L_ROOT;
        end
        L_ROOT: begin
          // one result bit per cycle, msb first
          if (22'(t_sq) <= s_r) n_r <= t;
          if (k_r == 3'd0) state_r <= L_ROUND;
          k_r <= k_r - 3'd1;
        end
        L_ROUND: begin
          if (s_r > ROOT_SAT) mag_r <= MAG_MAX;
          else if (s_r > 22'(n_lim)) mag_r <= n_r + 8'd1;
          else mag_r <= n_r;
          done_r  <= 1'b1;
          state_r <= L_IDLE;
        end
        default: state_r <= L_IDLE;
      endcase
    end
  end

  assign done = done_r;
  assign mag  = mag_r;

endmodule

>>> hdl/rgb_sobel_edge_magnitude_top.sv
// An item with no result (the first width+1 positions of a frame) passes only
// S_IDLE and S_SHIFT; an item that yields a pixel also passes S_START, S_WAIT
// (gradient, squaring, the bit-serial square root in each of the three colour
// lanes, rounding) and S_PUT (output hand-over). One item is in flight at a time;
// the next is taken while a finished pixel still waits in the output register.
// Line store: two banks of MAX_WIDTH pixels, one read and one write port each.
// ----------------------------------------------------------------------------
// rgb_sobel_edge_magnitude_top
// per-channel 3x3 sobel magnitude over a raster rgb stream, zero padded
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "rgb_sobel_edge_magnitude_top_defines.svh"

module rgb_sobel_edge_magnitude_top #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [rsem_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [rsem_pkg::CFG_BITS-1:0]     cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [rsem_pkg::PIX_BITS-1:0]     in_blue,
  input  logic [rsem_pkg::PIX_BITS-1:0]     in_green,
  input  logic [rsem_pkg::PIX_BITS-1:0]     in_red,
  input  logic                              in_drain,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [rsem_pkg::PIX_BITS-1:0]     out_blue,
  output logic [rsem_pkg::PIX_BITS-1:0]     out_green,
  output logic [rsem_pkg::PIX_BITS-1:0]     out_red,
  output logic                              out_frame_end
);
  import rsem_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = CW + 1;

  typedef enum logic [2:0] {S_IDLE, S_SHIFT, S_START, S_WAIT, S_PUT} state_t;

  state_t               state_r;
  logic [FW_BITS-1:0]   fw_r;
  logic [FH_BITS-1:0]   fh_r;
  logic [CW-1:0]        in_col_r, out_col_r;
  logic [FH_BITS:0]     in_row_r;
  logic [FH_BITS-1:0]   out_row_r;
  logic [23:0]          win_r [3][3];  // [column][row]
  logic [23:0]          pix_r;
  logic                 emit_r;
  logic [23:0]          bank0 [MAX_WIDTH];
  logic [23:0]          bank1 [MAX_WIDTH];
  logic [23:0]          rd0_r, rd1_r;
  logic                 out_valid_r, out_end_r;
  logic [PIX_BITS-1:0]  out_b_r, out_g_r, out_r_r;

  logic [WW-1:0]        effw;
  logic [FH_BITS-1:0]   effh;
  logic                 in_acc;
  logic [WW-1:0]        col_inc;
  logic                 last;
  logic                 restart;
  edge_mask_t           mask;
  logic [2:0]           lane_done;
  logic [PIX_BITS-1:0]  lane_mag [3];
  logic [23:0]          up2, up1;

  always_comb begin
    if (fw_r == '0) effw = WW'(1);
    else if (32'(fw_r) > 32'(MAX_WIDTH)) effw = WW'(MAX_WIDTH);
    else effw = WW'(fw_r);
    effh = (fh_r == '0) ? FH_BITS'(1) : fh_r;
  end

  assign in_acc  = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign col_inc = WW'(in_col_r) + WW'(1);
  assign last    = (out_row_r == effh - FH_BITS'(1)) && (WW'(out_col_r) == effw - WW'(1));
  assign restart = (state_r == S_PUT) && (!out_valid_r || !out_stall) && last;

  assign mask.col_ok = {WW'(out_col_r) != effw - WW'(1), 1'b1, out_col_r != '0};
  assign mask.row_ok = {out_row_r != effh - FH_BITS'(1), 1'b1, out_row_r != '0};

  // even rows write bank0, odd rows bank1; read before write on the same column
  assign up2 = in_row_r[0] ? rd1_r : rd0_r;
  assign up1 = in_row_r[0] ? rd0_r : rd1_r;

  always_ff @(posedge clk) begin
    if (in_acc) rd0_r <= bank0[in_col_r];
    if (state_r == S_SHIFT && !in_row_r[0]) bank0[in_col_r] <= pix_r;
  end

  always_ff @(posedge clk) begin
    if (in_acc) rd1_r <= bank1[in_col_r];
    if (state_r == S_SHIFT && in_row_r[0]) bank1[in_col_r] <= pix_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fw_r        <= FW_BITS'(1024);
      fh_r        <= FH_BITS'(1024);
      in_col_r    <= '0;
      in_row_r    <= '0;
      out_col_r   <= '0;
      out_row_r   <= '0;
      out_valid_r <= 1'b0;
      for (int c = 0; c < 3; c++) for (int r = 0; r < 3; r++) win_r[c][r] <= '0;
    end else begin
      if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      if (cfg_wr_en && (cfg_index == REG_FRAME_WIDTH || cfg_index == REG_FRAME_HEIGHT)) begin
        if (cfg_index == REG_FRAME_WIDTH) fw_r <= cfg_data[FW_BITS-1:0];
        else fh_r <= cfg_data;
        in_col_r  <= '0;
        in_row_r  <= '0;
        out_col_r <= '0;
        out_row_r <= '0;
        for (int c = 0; c < 3; c++) for (int r = 0; r < 3; r++) win_r[c][r] <= '0;
      end else begin
        case (state_r)
          S_IDLE: begin
            if (in_acc) begin
              pix_r   <= (!in_drain && in_row_r < 17'(effh)) ? {in_red, in_green, in_blue} : '0;
              emit_r  <= !(in_row_r == '0 || (in_row_r == 17'd1 && in_col_r == '0));
              state_r <= S_SHIFT;
            end
          end
          S_SHIFT: begin
            win_r[0] <= win_r[1];
            win_r[1] <= win_r[2];
            win_r[2][0] <= up2;
            win_r[2][1] <= up1;
            win_r[2][2] <= pix_r;
            if (col_inc >= effw) begin
              in_col_r <= '0;
              in_row_r <= in_row_r + 17'd1;
            end else begin
              in_col_r <= CW'(col_inc);
            end
            state_r <= emit_r ? S_START : S_IDLE;
          end
          S_START: state_r <= S_WAIT;
          S_WAIT:  if (lane_done[0]) state_r <= S_PUT;
          S_PUT: begin
            if (!out_valid_r || !out_stall) begin
              out_valid_r <= 1'b1;
              out_b_r     <= lane_mag[0];
              out_g_r     <= lane_mag[1];
              out_r_r     <= lane_mag[2];
              out_end_r   <= last;
              if (last) begin
                in_col_r  <= '0;
                in_row_r  <= '0;
                out_col_r <= '0;
                out_row_r <= '0;
                for (int c = 0; c < 3; c++) for (int r = 0; r < 3; r++) win_r[c][r] <= '0;
              end else if (WW'(out_col_r) == effw - WW'(1)) begin
                out_col_r <= '0;
                out_row_r <= out_row_r + FH_BITS'(1);
              end else begin
                out_col_r <= out_col_r + CW'(1);
              end
              state_r <= S_IDLE;
            end
          end
          default: state_r <= S_IDLE;
        endcase
      end
    end
  end

  for (genvar ch = 0; ch < 3; ch++) begin : g_lane
    win_bytes_t wb;
    always_comb begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          wb[r][c] = win_r[c][r][PIX_BITS*ch +: PIX_BITS];
        end
      end
    end
    rsem_lane u_lane (
      .clk   (clk),
      .rst_n (rst_n),
      .start (state_r == S_START),
      .win   (wb),
      .mask  (mask),
      .done  (lane_done[ch]),
      .mag   (lane_mag[ch])
    );
  end

  assign out_valid     = out_valid_r;
  assign out_blue      = out_b_r;
  assign out_green     = out_g_r;
  assign out_red       = out_r_r;
  assign out_frame_end = out_end_r;

  `RSEM_ASSERT(a_lanes_in_step, lane_done == 3'b000 || lane_done == 3'b111)
  `RSEM_ASSERT(a_done_when_waiting, lane_done[0] |-> state_r == S_WAIT)
  `RSEM_ASSERT(a_hold_waiting_pixel, (state_r == S_PUT && out_valid_r && out_stall && !cfg_wr_en) |=> state_r == S_PUT)
  `RSEM_NEVER(a_restart_clears, $past(restart) && !$past(cfg_wr_en) && $past(rst_n) && (in_row_r != '0 || out_row_r != '0))

endmodule
